// ===== rtl/nbh_pkg.sv =====
// Shared types, codes and helpers for the nebulabrot orbit histogram.
// Used by every file in rtl/; depends on nothing.
package nbh_pkg;

	localparam int IMG_WIDTH_DEF  = 256;
	localparam int IMG_HEIGHT_DEF = 256;

	// operation codes of an input item
	localparam logic [1:0] OP_TRACE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_VIEW_MIN_RE  = 3'd0;
	localparam logic [2:0] CFG_VIEW_MIN_IM  = 3'd1;
	localparam logic [2:0] CFG_PPU_RE       = 3'd2;
	localparam logic [2:0] CFG_PPU_IM       = 3'd3;
	localparam logic [2:0] CFG_MAX_ITER     = 3'd4;
	localparam logic [2:0] CFG_GREEN_LIMIT  = 3'd5;
	localparam logic [2:0] CFG_BLUE_LIMIT   = 3'd6;

	// |z|^2 threshold 4.0 in Q8.56
	localparam logic [64:0] ESC_LIMIT = 65'd4 << 56;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_AA,
		ST_MUL_BB,
		ST_MUL_AB,
		ST_TEST,
		ST_MAP_RE,
		ST_MAP_IM,
		ST_ADDR,
		ST_WR,
		ST_OP_RD,
		ST_DONE
	} nbh_state_t;

	// per-channel histogram write enables
	typedef struct packed {
		logic red;
		logic green;
		logic blue;
	} hist_wen_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -66'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
	endfunction

endpackage

// ===== rtl/nbh_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
// Depends on nbh_pkg.
module nbh_mul
	import nbh_pkg::*;
(
	input  logic               clk,
	input  logic signed [32:0] op_a,
	input  logic signed [32:0] op_b,
	output logic signed [65:0] prod_s1
);

	// one product per cycle, ready the cycle after its operands
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

endmodule

// ===== rtl/nbh_hist.sv =====
// Red, green and blue histogram memories with a clearing sweep after reset.
// Depends on nbh_pkg.
module nbh_hist
	import nbh_pkg::*;
#(
	parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = IMG_HEIGHT_DEF,
	localparam int PIXELS    = IMG_WIDTH * IMG_HEIGHT,
	localparam int ADDR_W    = $clog2(PIXELS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] addr,
	input  logic              rd_en,
	input  hist_wen_t         wen,
	input  logic [31:0]       wr_red,
	input  logic [31:0]       wr_green,
	input  logic [31:0]       wr_blue,
	output logic [31:0]       rd_red,
	output logic [31:0]       rd_green,
	output logic [31:0]       rd_blue,
	output logic              busy
);

	logic [31:0] red_mem   [PIXELS];
	logic [31:0] green_mem [PIXELS];
	logic [31:0] blue_mem  [PIXELS];

	logic [ADDR_W:0] clr_q;

	assign busy = (clr_q < (ADDR_W+1)'(PIXELS));

	// clearing sweep pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// memory ports: sweep writes zero, otherwise the user port
	always_ff @(posedge clk) begin
		if (busy) begin
			red_mem[clr_q[ADDR_W-1:0]]   <= '0;
			green_mem[clr_q[ADDR_W-1:0]] <= '0;
			blue_mem[clr_q[ADDR_W-1:0]]  <= '0;
		end else begin
			if (wen.red)   red_mem[addr]   <= wr_red;
			if (wen.green) green_mem[addr] <= wr_green;
			if (wen.blue)  blue_mem[addr]  <= wr_blue;
		end
		if (rd_en) begin
			rd_red   <= red_mem[addr];
			rd_green <= green_mem[addr];
			rd_blue  <= blue_mem[addr];
		end
	end

endmodule

// ===== rtl/nebulabrot_orbit_histogram.sv =====
// Nebulabrot orbit histogram: top level with the step sequencer.
// Depends on nbh_pkg, nbh_mul and nbh_hist.
//
// After reset the three histograms are swept to zero, one pixel per cycle,
// over all IMG_WIDTH*IMG_HEIGHT pixels (65536 at the default size); no item
// is taken meanwhile, configuration writes are. A trace item runs its orbit
// through one shared 33x33 multiplier: each tested step forms the three
// squares/products and tests them; then, if it escaped at step i, it replays
// i steps, each with the three squares/products, two pixel mappings, and a
// read-modify-write of the histograms only when the orbit point lands in the
// window. Read and clear items pass through ST_OP_RD to ST_DONE.
// One item is in work at a time; its result sits in an
// output register, and the next item is taken while that result still waits.
module nebulabrot_orbit_histogram
	import nbh_pkg::*;
#(
	parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = IMG_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] point_re,
	input  logic signed [31:0] point_im,
	input  logic [7:0]         pixel_col,
	input  logic [7:0]         pixel_row,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               escaped,
	output logic [11:0]        escape_step,
	output logic [31:0]        red_count,
	output logic [31:0]        green_count,
	output logic [31:0]        blue_count
);

	localparam int ADDR_W = $clog2(IMG_WIDTH * IMG_HEIGHT);
	localparam int COL_W  = $clog2(IMG_WIDTH);
	localparam int ROW_W  = $clog2(IMG_HEIGHT);
	localparam logic [65:0] LIM_RE = 66'(IMG_WIDTH) << 44;
	localparam logic [65:0] LIM_IM = 66'(IMG_HEIGHT) << 44;

	// configuration
	logic signed [31:0] vmin_re_q, vmin_im_q;
	logic [31:0]        ppu_re_q, ppu_im_q;
	logic [11:0]        max_iter_q, green_lim_q, blue_lim_q;

	nbh_state_t state_q, state_d;
	logic       replay_q, out_valid_q;

	// working registers
	logic [1:0]         op_q;
	logic signed [31:0] cre_q, cim_q, zr_q, zi_q;
	logic [63:0]        aa_q, bb_q;
	logic [11:0]        i_q, j_q, steps_q;
	logic [COL_W-1:0]   col_q;
	logic               re_in_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               res_esc_q;
	logic [11:0]        res_step_q;
	logic [31:0]        res_red_q, res_green_q, res_blue_q;
	logic               esc_out_q;
	logic [11:0]        step_out_q;
	logic [31:0]        red_out_q, green_out_q, blue_out_q;

	// shared multiplier and histograms
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_s1;
	logic               h_rd_en, h_busy;
	hist_wen_t          h_wen;
	logic [ADDR_W-1:0]  h_addr;
	logic [31:0]        h_wr_red, h_wr_green, h_wr_blue;
	logic [31:0]        h_rd_red, h_rd_green, h_rd_blue;

	nbh_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.prod_s1 (prod_s1)
	);

	nbh_hist #(
		.IMG_WIDTH  (IMG_WIDTH),
		.IMG_HEIGHT (IMG_HEIGHT)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.addr     (h_addr),
		.rd_en    (h_rd_en),
		.wen      (h_wen),
		.wr_red   (h_wr_red),
		.wr_green (h_wr_green),
		.wr_blue  (h_wr_blue),
		.rd_red   (h_rd_red),
		.rd_green (h_rd_green),
		.rd_blue  (h_rd_blue),
		.busy     (h_busy)
	);

	// handshake
	logic acc, out_free;
	assign in_stall  = (state_q != ST_IDLE) || h_busy;
	assign acc       = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// pixel address of a read or clear item
	logic              pix_ok;
	logic [ADDR_W-1:0] pix_addr;
	assign pix_ok   = (32'(pixel_col) < IMG_WIDTH) && (32'(pixel_row) < IMG_HEIGHT);
	assign pix_addr = ADDR_W'(32'(pixel_row) * IMG_WIDTH + 32'(pixel_col));
	logic op_rd;
	assign op_rd = (operation == OP_READ) || (operation == OP_CLEAR);

	// escape test and one orbit step from the registered products
	logic [64:0]        mag;
	logic               esc, iter_ok;
	logic signed [65:0] diff;
	logic signed [31:0] nre, nim;
	assign mag     = {1'b0, aa_q} + {1'b0, bb_q};
	assign esc     = (mag >= ESC_LIMIT);
	assign iter_ok = (i_q < max_iter_q);
	assign diff    = $signed({2'b00, aa_q}) - $signed({2'b00, bb_q});
	assign nre     = sat32((diff >>> 28) + 66'(cre_q));
	assign nim     = sat32((prod_s1 >>> 27) + 66'(cim_q));

	// offsets from the window origin
	logic signed [33:0] d_re, d_im;
	assign d_re = 34'(zr_q) - 34'(vmin_re_q);
	assign d_im = 34'(zi_q) - 34'(vmin_im_q);

	// column from the product ready in ST_MAP_IM, clamped on the upper edge
	logic             re_in;
	logic [COL_W-1:0] col_idx;
	logic [21:0]      raw_col, raw_row;
	assign raw_col = prod_s1[65:44];
	assign re_in   = !d_re[33] && ($unsigned(prod_s1) <= LIM_RE);
	assign col_idx = (32'(raw_col) >= IMG_WIDTH) ? COL_W'(IMG_WIDTH - 1) : raw_col[COL_W-1:0];

	// row from the product ready in ST_ADDR
	logic             im_in, both_in;
	logic [ROW_W-1:0] row_idx;
	logic [ADDR_W-1:0] map_addr;
	assign raw_row  = prod_s1[65:44];
	assign im_in    = !d_im[33] && ($unsigned(prod_s1) <= LIM_IM);
	assign row_idx  = (32'(raw_row) >= IMG_HEIGHT) ? ROW_W'(IMG_HEIGHT - 1)
	                                              : raw_row[ROW_W-1:0];
	assign both_in  = re_in_q && im_in;
	assign map_addr = ADDR_W'(32'(row_idx) * IMG_WIDTH + 32'(col_q));

	logic last;
	assign last = ((j_q + 12'd1) == steps_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (operation == OP_TRACE) state_d = ST_MUL_AA;
					else if (op_rd && pix_ok) state_d = ST_OP_RD;
					else state_d = ST_DONE;
				end
			end
			ST_MUL_AA: state_d = ST_MUL_BB;
			ST_MUL_BB: state_d = ST_MUL_AB;
			ST_MUL_AB: state_d = ST_TEST;
			ST_TEST: begin
				if (replay_q) state_d = ST_MAP_RE;
				else if (!iter_ok) state_d = ST_DONE;
				else if (esc && (i_q == 12'd0)) state_d = ST_DONE;
				else state_d = ST_MUL_AA;
			end
			ST_MAP_RE: state_d = ST_MAP_IM;
			ST_MAP_IM: state_d = ST_ADDR;
			ST_ADDR: begin
				if (both_in) state_d = ST_WR;
				else state_d = last ? ST_DONE : ST_MUL_AA;
			end
			ST_WR:    state_d = last ? ST_DONE : ST_MUL_AA;
			ST_OP_RD: state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// multiplier operands and histogram port
	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		h_rd_en    = 1'b0;
		h_wen      = '0;
		h_addr     = addr_q;
		h_wr_red   = '0;
		h_wr_green = '0;
		h_wr_blue  = '0;
		case (state_q)
			ST_IDLE: begin
				h_addr  = pix_addr;
				h_rd_en = acc && op_rd && pix_ok;
			end
			ST_MUL_AA: begin
				mul_a = 33'(zr_q);
				mul_b = 33'(zr_q);
			end
			ST_MUL_BB: begin
				mul_a = 33'(zi_q);
				mul_b = 33'(zi_q);
			end
			ST_MUL_AB: begin
				mul_a = 33'(zr_q);
				mul_b = 33'(zi_q);
			end
			ST_MAP_RE: begin
				mul_a = $signed({1'b0, d_re[31:0]});
				mul_b = $signed({1'b0, ppu_re_q});
			end
			ST_MAP_IM: begin
				mul_a = $signed({1'b0, d_im[31:0]});
				mul_b = $signed({1'b0, ppu_im_q});
			end
			ST_ADDR: begin
				h_addr  = map_addr;
				h_rd_en = both_in;
			end
			ST_WR: begin
				h_wen.red   = 1'b1;
				h_wen.green = (j_q < green_lim_q);
				h_wen.blue  = (j_q < blue_lim_q);
				h_wr_red    = bump(h_rd_red);
				h_wr_green  = bump(h_rd_green);
				h_wr_blue   = bump(h_rd_blue);
			end
			ST_OP_RD: begin
				if (op_q == OP_CLEAR) h_wen = '{red: 1'b1, green: 1'b1, blue: 1'b1};
			end
			default: ;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			replay_q    <= 1'b0;
			out_valid_q <= 1'b0;
			vmin_re_q   <= -32'sd536870912;
			vmin_im_q   <= -32'sd536870912;
			ppu_re_q    <= 32'd4194304;
			ppu_im_q    <= 32'd4194304;
			max_iter_q  <= 12'd2000;
			green_lim_q <= 12'd200;
			blue_lim_q  <= 12'd20;
		end else begin
			state_q <= state_d;
			if (acc) replay_q <= 1'b0;
			else if (state_q == ST_TEST && !replay_q && iter_ok && esc) replay_q <= 1'b1;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_VIEW_MIN_RE: vmin_re_q   <= cfg_data;
					CFG_VIEW_MIN_IM: vmin_im_q   <= cfg_data;
					CFG_PPU_RE:      ppu_re_q    <= cfg_data;
					CFG_PPU_IM:      ppu_im_q    <= cfg_data;
					CFG_MAX_ITER:    max_iter_q  <= cfg_data[11:0];
					CFG_GREEN_LIMIT: green_lim_q <= cfg_data[11:0];
					CFG_BLUE_LIMIT:  blue_lim_q  <= cfg_data[11:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					op_q        <= operation;
					cre_q       <= point_re;
					cim_q       <= point_im;
					zr_q        <= point_re;
					zi_q        <= point_im;
					i_q         <= '0;
					j_q         <= '0;
					addr_q      <= pix_addr;
					res_esc_q   <= 1'b0;
					res_step_q  <= '0;
					res_red_q   <= '0;
					res_green_q <= '0;
					res_blue_q  <= '0;
				end
			end
			ST_MUL_BB: aa_q <= prod_s1[63:0];
			ST_MUL_AB: bb_q <= prod_s1[63:0];
			ST_TEST: begin
				if (replay_q) begin
					zr_q <= nre;
					zi_q <= nim;
				end else if (iter_ok && esc) begin
					res_esc_q  <= 1'b1;
					res_step_q <= i_q;
					steps_q    <= i_q;
					zr_q       <= cre_q;
					zi_q       <= cim_q;
				end else if (iter_ok) begin
					zr_q <= nre;
					zi_q <= nim;
					i_q  <= i_q + 12'd1;
				end
			end
			ST_MAP_IM: begin
				col_q   <= col_idx;
				re_in_q <= re_in;
			end
			ST_ADDR: begin
				addr_q <= map_addr;
				if (!both_in) j_q <= j_q + 12'd1;
			end
			ST_WR: j_q <= j_q + 12'd1;
			ST_OP_RD: begin
				res_red_q   <= h_rd_red;
				res_green_q <= h_rd_green;
				res_blue_q  <= h_rd_blue;
			end
			ST_DONE: begin
				if (out_free) begin
					esc_out_q   <= res_esc_q;
					step_out_q  <= res_step_q;
					red_out_q   <= res_red_q;
					green_out_q <= res_green_q;
					blue_out_q  <= res_blue_q;
				end
			end
			default: ;
		endcase
	end

	assign escaped     = esc_out_q;
	assign escape_step = step_out_q;
	assign red_count   = red_out_q;
	assign green_count = green_out_q;
	assign blue_count  = blue_out_q;

	// histograms are written only in the update or clear step
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		(h_wen.red || h_wen.green || h_wen.blue) |->
		(state_q == ST_WR || state_q == ST_OP_RD))
		else $error("histogram write outside update step");

	// replay never runs past the escape step
	a_replay_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(replay_q && state_q == ST_TEST) |-> (j_q < steps_q))
		else $error("replay counter past escape step");

	// a new result appears only when the sequencer hands one over
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result without finished item");

	// no item is taken during the clearing sweep
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		h_busy |-> !acc)
		else $error("item accepted while clearing");

endmodule
